// ===== src/wibf_pkg.sv =====
// ============================================================================
// wibf_pkg : WebAssembly instruction boundary finder, shared definitions
// Opcode values, parser phases, error codes and the result record.
// ============================================================================
package wibf_pkg;

    // Deepest block nesting tracked before an overflow error
    localparam int MAX_NESTING = 64;
    localparam int DEPTH_W     = $clog2(MAX_NESTING + 1);
    localparam int MARK_AW     = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

    localparam int BYTE_W      = 8;
    localparam int LEB_IDX_W   = 3;
    localparam int COUNT_W     = 32;
    localparam int LEBS_W      = COUNT_W + 1;
    localparam int OUT_DEPTH_W = 7;

    // LEB byte position at which a set continuation bit is an error
    localparam logic [LEB_IDX_W-1:0] LEB_LAST_IDX = 3'd4;

    // Opcodes
    localparam logic [BYTE_W-1:0] OP_END           = 8'h0B;
    localparam logic [BYTE_W-1:0] OP_ELSE          = 8'h05;
    localparam logic [BYTE_W-1:0] OP_BLOCK         = 8'h02;
    localparam logic [BYTE_W-1:0] OP_LOOP          = 8'h03;
    localparam logic [BYTE_W-1:0] OP_IF            = 8'h04;
    localparam logic [BYTE_W-1:0] OP_BR            = 8'h0C;
    localparam logic [BYTE_W-1:0] OP_BR_IF         = 8'h0D;
    localparam logic [BYTE_W-1:0] OP_BR_TBL        = 8'h0E;
    localparam logic [BYTE_W-1:0] OP_CALL          = 8'h10;
    localparam logic [BYTE_W-1:0] OP_CALL_IND      = 8'h11;
    localparam logic [BYTE_W-1:0] RESERVED_BYTE    = 8'h00;
    localparam logic [BYTE_W-1:0] OP_VAR_FIRST     = 8'h20;
    localparam logic [BYTE_W-1:0] OP_VAR_LAST      = 8'h24;
    localparam logic [BYTE_W-1:0] OP_MEM_FIRST     = 8'h28;
    localparam logic [BYTE_W-1:0] OP_MEM_LAST      = 8'h3E;

    // Error codes
    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_RESERVED = 2'd1,
        ERR_NESTING  = 2'd2,
        ERR_LEB      = 2'd3
    } t_err;

    // Parser phase, one-hot
    typedef enum logic [5:0] {
        PH_OPCODE      = 6'b000001,
        PH_BLOCKTYPE   = 6'b000010,
        PH_SKIP        = 6'b000100,
        PH_COUNT       = 6'b001000,
        PH_CI_LEB      = 6'b010000,
        PH_CI_RESERVED = 6'b100000
    } t_phase;

    typedef struct packed {
        logic                   instruction_done;
        t_err                   error_code;
        logic [OUT_DEPTH_W-1:0] nesting_depth;
    } t_result;

endpackage

// ===== src/wasm_instruction_boundary_finder_top.sv =====
// ============================================================================
// wasm_instruction_boundary_finder_top : WebAssembly instruction boundaries
// Walks a code stream one byte per item and flags the byte that closes each
// outermost instruction, with block nesting depth and error reporting.
// ============================================================================
//
//  Channel | Direction | Handshake                   | Payload
//  --------+-----------+-----------------------------+---------------------------
//  in      | sink      | i_in_valid / o_in_stall     | i_code_byte[7:0]
//  out     | source    | o_out_valid / i_out_stall   | o_instruction_done,
//          |           |                             | o_error_code[1:0],
//          |           |                             | o_nesting_depth[6:0]
//
//  - One byte accepted per clock while o_in_stall is low; every byte gives exactly one result item.
//  - The parser state and the result (in the output or skid register) are
//    updated at the edge that accepts the byte.
//  - A two-entry output (result register plus skid register) keeps input
//    acceptance going while a result waits; o_in_stall rises only once both
//    hold an item, and comes straight from a flop.
//  - Synchronous active-low reset returns the parser to "expect opcode" at
//    depth zero and empties the output. The if/else marks are not reset:
//    a level's mark is always written when the level opens.
//  - Any error sends the parser back to its reset state; the next byte is
//    taken as an outermost opcode.
//
module wasm_instruction_boundary_finder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_code_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_instruction_done,
    output logic [1:0] o_error_code,
    output logic [6:0] o_nesting_depth
);

    localparam int DW = wibf_pkg::DEPTH_W;
    localparam int AW = wibf_pkg::MARK_AW;

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    wibf_pkg::t_phase                    r_phase, n_phase;
    logic [wibf_pkg::LEBS_W-1:0]         r_lebs, n_lebs;     // LEBs left to skip
    logic [wibf_pkg::COUNT_W-1:0]        r_acc, n_acc;       // branch table count
    logic [wibf_pkg::LEB_IDX_W-1:0]      r_idx, n_idx;       // byte within LEB
    logic [DW-1:0]                       r_depth, n_depth;

    // If/else marks: one bit per open level. The top level's mark and the
    // one below it are held in flops so that an else or an end never waits
    // on a memory read; the memory is read ahead for the level below top.
    logic                                r_mark_mem [wibf_pkg::MAX_NESTING];
    logic                                r_top_mark, n_top_mark;
    logic                                r_below_mark;
    logic                                mark_we;
    logic [AW-1:0]                       mark_wa;
    logic                                mark_wd;
    logic [AW-1:0]                       mark_ra;

    // Output register and skid register
    logic                                r_out_valid;
    wibf_pkg::t_result                   r_out;
    logic                                r_skid_valid;
    wibf_pkg::t_result                   r_skid;

    logic                                in_accept;
    logic                                out_take;
    wibf_pkg::t_result                   res;

    // Combinational helpers
    logic [7:0]                          b;
    logic                                leb_end;
    logic                                leb_over;
    logic [wibf_pkg::LEB_IDX_W-1:0]      idx_inc;
    logic [4:0]                          shamt;
    logic [wibf_pkg::COUNT_W-1:0]        acc_or;
    logic [wibf_pkg::LEBS_W-1:0]         lebs_dec;
    logic [DW-1:0]                       depth_m1;
    logic [DW-1:0]                       ndepth_m2;
    logic                                depth_open;
    logic                                finished;
    wibf_pkg::t_err                      err;

    assign in_accept  = i_in_valid && !r_skid_valid;
    assign out_take   = r_out_valid && !i_out_stall;
    assign o_in_stall = r_skid_valid;

    assign b        = i_code_byte;
    assign leb_end  = !b[7];
    assign leb_over = b[7] && (r_idx >= wibf_pkg::LEB_LAST_IDX);
    assign idx_inc  = r_idx + 1'b1;
    assign shamt    = {2'b00, r_idx} * 5'd7;
    assign acc_or   = (r_idx <= wibf_pkg::LEB_LAST_IDX)
                      ? (r_acc | (wibf_pkg::COUNT_W'(b[6:0]) << shamt)) : r_acc;
    assign lebs_dec = (r_lebs != '0) ? (r_lebs - 1'b1) : r_lebs;
    assign depth_m1 = r_depth - 1'b1;
    assign depth_open = (r_depth != '0) && (r_depth <= DW'(wibf_pkg::MAX_NESTING));

    // ------------------------------------------------------------------
    // Next-state and result
    // ------------------------------------------------------------------
    always_comb begin
        n_phase    = r_phase;
        n_lebs     = r_lebs;
        n_acc      = r_acc;
        n_idx      = r_idx;
        n_depth    = r_depth;
        n_top_mark = r_top_mark;
        mark_we    = 1'b0;
        mark_wa    = r_depth[AW-1:0];
        mark_wd    = 1'b0;
        finished   = 1'b0;
        err        = wibf_pkg::ERR_NONE;

        unique case (r_phase)
            wibf_pkg::PH_BLOCKTYPE: begin
                n_phase = wibf_pkg::PH_OPCODE;      // block type: single byte
            end
            wibf_pkg::PH_SKIP: begin
                if (leb_over) begin
                    err = wibf_pkg::ERR_LEB;
                end else if (leb_end) begin
                    n_idx  = '0;
                    n_lebs = lebs_dec;
                    if (lebs_dec == '0) begin
                        finished = 1'b1;
                    end
                end else begin
                    n_idx = idx_inc;
                end
            end
            wibf_pkg::PH_COUNT: begin
                n_acc = acc_or;
                if (leb_over) begin
                    err = wibf_pkg::ERR_LEB;
                end else if (leb_end) begin
                    // labels plus the default one
                    n_idx   = '0;
                    n_lebs  = wibf_pkg::LEBS_W'(acc_or) + 1'b1;
                    n_acc   = '0;
                    n_phase = wibf_pkg::PH_SKIP;
                end else begin
                    n_idx = idx_inc;
                end
            end
            wibf_pkg::PH_CI_LEB: begin
                if (leb_over) begin
                    err = wibf_pkg::ERR_LEB;
                end else if (leb_end) begin
                    n_idx   = '0;
                    n_phase = wibf_pkg::PH_CI_RESERVED;
                end else begin
                    n_idx = idx_inc;
                end
            end
            wibf_pkg::PH_CI_RESERVED: begin
                if (b == wibf_pkg::RESERVED_BYTE) begin
                    finished = 1'b1;
                end else begin
                    err = wibf_pkg::ERR_RESERVED;
                end
            end
            default: begin                          // expecting an opcode
                n_phase = wibf_pkg::PH_OPCODE;
                priority if (depth_open && b == wibf_pkg::OP_END) begin
                    n_depth    = depth_m1;
                    n_top_mark = r_below_mark;
                    finished   = 1'b1;
                end else if (depth_open && b == wibf_pkg::OP_ELSE && r_top_mark) begin
                    mark_we    = 1'b1;
                    mark_wa    = depth_m1[AW-1:0];
                    mark_wd    = 1'b0;
                    n_top_mark = 1'b0;
                end else if (b == wibf_pkg::OP_BLOCK || b == wibf_pkg::OP_LOOP ||
                             b == wibf_pkg::OP_IF) begin
                    if (r_depth >= DW'(wibf_pkg::MAX_NESTING)) begin
                        err = wibf_pkg::ERR_NESTING;
                    end else begin
                        mark_we    = 1'b1;
                        mark_wa    = r_depth[AW-1:0];
                        mark_wd    = (b == wibf_pkg::OP_IF);
                        n_top_mark = (b == wibf_pkg::OP_IF);
                        n_depth    = r_depth + 1'b1;
                        n_phase    = wibf_pkg::PH_BLOCKTYPE;
                    end
                end else if (b == wibf_pkg::OP_BR || b == wibf_pkg::OP_BR_IF ||
                             b == wibf_pkg::OP_CALL ||
                             (b >= wibf_pkg::OP_VAR_FIRST && b <= wibf_pkg::OP_VAR_LAST)) begin
                    n_lebs  = wibf_pkg::LEBS_W'(1);
                    n_idx   = '0;
                    n_phase = wibf_pkg::PH_SKIP;
                end else if (b >= wibf_pkg::OP_MEM_FIRST && b <= wibf_pkg::OP_MEM_LAST) begin
                    n_lebs  = wibf_pkg::LEBS_W'(2);     // alignment and offset
                    n_idx   = '0;
                    n_phase = wibf_pkg::PH_SKIP;
                end else if (b == wibf_pkg::OP_BR_TBL) begin
                    n_acc   = '0;
                    n_idx   = '0;
                    n_phase = wibf_pkg::PH_COUNT;
                end else if (b == wibf_pkg::OP_CALL_IND) begin
                    n_idx   = '0;
                    n_phase = wibf_pkg::PH_CI_LEB;
                end else begin
                    finished = 1'b1;
                end
            end
        endcase

        res.instruction_done = 1'b0;
        res.error_code       = err;
        if (err != wibf_pkg::ERR_NONE) begin
            n_phase = wibf_pkg::PH_OPCODE;
            n_lebs  = '0;
            n_acc   = '0;
            n_idx   = '0;
            n_depth = '0;
        end else if (finished) begin
            n_phase = wibf_pkg::PH_OPCODE;
            n_lebs  = '0;
            n_idx   = '0;
            res.instruction_done = (n_depth == '0);
        end
        res.nesting_depth = wibf_pkg::OUT_DEPTH_W'(n_depth);
    end

    // Read ahead the mark of the level that will sit below the top
    assign ndepth_m2 = n_depth - DW'(2);
    assign mark_ra   = (n_depth >= DW'(2)) ? ndepth_m2[AW-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (in_accept && mark_we) begin
            r_mark_mem[mark_wa] <= mark_wd;
        end
        if (in_accept) begin
            r_below_mark <= r_mark_mem[mark_ra];
            r_top_mark   <= n_top_mark;
            r_lebs       <= n_lebs;
            r_acc        <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= wibf_pkg::PH_OPCODE;
            r_idx   <= '0;
            r_depth <= '0;
        end else if (in_accept) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_depth <= n_depth;
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_take) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (in_accept) begin
                if (!r_out_valid || out_take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (in_accept) begin
            if (!r_out_valid || out_take) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_instruction_done = r_out.instruction_done;
    assign o_error_code       = r_out.error_code;
    assign o_nesting_depth    = r_out.nesting_depth;

endmodule

// ===== src/wibf_checker.sv =====
// ============================================================================
// wibf_checker : port-level checks for the instruction boundary finder
// Watches the top level's ports and flags handshake and result slips.
// ============================================================================
module wibf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_instruction_done,
    input logic [1:0] o_error_code,
    input logic [6:0] o_nesting_depth
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_instruction_done)
            && $stable(o_error_code) && $stable(o_nesting_depth))
        else $error("result changed while stalled");

    // an accepted item always leaves a result waiting next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted item produced no result");

    // input stalls only when the output side is full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output");

    // an error result carries no boundary and a cleared depth
    a_err_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error_code != wibf_pkg::ERR_NONE
            |-> !o_instruction_done && o_nesting_depth == 7'd0)
        else $error("error result with boundary or depth");

    // an outermost boundary only at depth zero
    a_done_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_instruction_done |-> o_nesting_depth == 7'd0)
        else $error("boundary flagged inside a block");

endmodule

bind wasm_instruction_boundary_finder_top wibf_checker u_wibf_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_stall         (o_in_stall),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_instruction_done (o_instruction_done),
    .o_error_code       (o_error_code),
    .o_nesting_depth    (o_nesting_depth)
);
